// ----- hdl/asgp_pkg.sv -----
// Package for the ADC sample group packer: sizes, sequencer states and
// the control struct passed from the sequencer to the group buffer.
// No dependencies.
package asgp_pkg;

  localparam int GROUP_SIZE = 4;
  localparam int SMP_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int LSB_W      = SMP_W - BYTE_W;
  localparam int HDR_W      = LSB_W * GROUP_SIZE;
  localparam int PLACE_W    = $clog2(GROUP_SIZE);
  localparam int FILL_W     = $clog2(GROUP_SIZE + 1);

  localparam logic [FILL_W-1:0] GROUP_CNT = FILL_W'(GROUP_SIZE);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_HDR,
    ST_MSB
  } state_e;

  typedef struct packed {
    logic               load;
    logic               clear;
    logic [PLACE_W-1:0] rd_idx;
  } buf_ctrl_t;

endpackage

// ----- hdl/asgp_group_buf.sv -----
// Group buffer: header low-bit pairs, MSB bytes and fill count of the
// open group, with the header pairs merged through one shift-and-OR unit.
// Depends on asgp_pkg.
module asgp_group_buf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  asgp_pkg::buf_ctrl_t             ctrl_i,
  input  logic [asgp_pkg::SMP_W-1:0]      sample_i,
  output logic [asgp_pkg::HDR_W-1:0]      header_o,
  output logic [asgp_pkg::BYTE_W-1:0]     rd_byte_o,
  output logic [asgp_pkg::FILL_W-1:0]     fill_o
);

  logic [asgp_pkg::HDR_W-1:0]  header_q, header_d;
  logic [asgp_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [asgp_pkg::BYTE_W-1:0] high_q [asgp_pkg::GROUP_SIZE];
  logic [asgp_pkg::PLACE_W-1:0] place;
  logic [asgp_pkg::HDR_W-1:0]  shifted;

  assign place   = fill_q[asgp_pkg::PLACE_W-1:0];
  assign shifted = asgp_pkg::HDR_W'(sample_i[asgp_pkg::LSB_W-1:0])
                   << (place * asgp_pkg::LSB_W);

  always_comb begin
    header_d = header_q;
    fill_d   = fill_q;
    if (ctrl_i.clear) begin
      header_d = '0;
      fill_d   = '0;
    end else if (ctrl_i.load) begin
      header_d = header_q | shifted;
      fill_d   = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
      fill_q   <= '0;
    end else begin
      header_q <= header_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && !ctrl_i.clear) begin
      high_q[place] <= sample_i[asgp_pkg::SMP_W-1:asgp_pkg::LSB_W];
    end
  end

  assign header_o  = header_q;
  assign rd_byte_o = high_q[ctrl_i.rd_idx];
  assign fill_o    = fill_q;

endmodule

// ----- hdl/asgp_ctrl.sv -----
// Sequencer: accepts samples while collecting, then walks the header and
// MSB bytes of a finished group out through the output channel.
// Depends on asgp_pkg.
module asgp_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            scan_end_i,
  input  logic [asgp_pkg::FILL_W-1:0]     fill_i,
  input  logic [asgp_pkg::HDR_W-1:0]      header_i,
  input  logic [asgp_pkg::BYTE_W-1:0]     rd_byte_i,
  output asgp_pkg::buf_ctrl_t             ctrl_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [asgp_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                            is_header_o,
  output logic                            msg_last_o
);

  asgp_pkg::state_e            state_q, state_d;
  logic [asgp_pkg::FILL_W-1:0] idx_q, idx_d, idx_nxt;
  logic                        end_q, end_d;
  logic                        in_acc;
  logic                        last_msb;

  assign idx_nxt  = idx_q + 1'b1;
  assign last_msb = (idx_nxt == fill_i);
  assign in_acc   = in_valid_i && (state_q == asgp_pkg::ST_COLLECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asgp_pkg::ST_COLLECT;
      idx_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    end_d         = end_q;
    ctrl_o.load   = 1'b0;
    ctrl_o.clear  = 1'b0;
    ctrl_o.rd_idx = idx_q[asgp_pkg::PLACE_W-1:0];
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    out_byte_o    = rd_byte_i;
    is_header_o   = 1'b0;
    msg_last_o    = 1'b0;
    unique case (state_q)
      asgp_pkg::ST_COLLECT: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          ctrl_o.load = 1'b1;
          if ((fill_i + 1'b1 == asgp_pkg::GROUP_CNT) || scan_end_i) begin
            state_d = asgp_pkg::ST_HDR;
            end_d   = scan_end_i;
          end
        end
      end
      asgp_pkg::ST_HDR: begin
        out_valid_o = 1'b1;
        out_byte_o  = header_i;
        is_header_o = 1'b1;
        if (!out_stall_i) begin
          state_d = asgp_pkg::ST_MSB;
          idx_d   = '0;
        end
      end
      asgp_pkg::ST_MSB: begin
        out_valid_o = 1'b1;
        msg_last_o  = end_q && last_msb;
        if (!out_stall_i) begin
          if (last_msb) begin
            ctrl_o.clear = 1'b1;
            state_d      = asgp_pkg::ST_COLLECT;
            idx_d        = '0;
          end else begin
            idx_d = idx_nxt;
          end
        end
      end
      default: begin
        state_d = asgp_pkg::ST_COLLECT;
      end
    endcase
  end

`ifndef SYNTH
  a_hdr_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asgp_pkg::ST_HDR) |-> (fill_i != '0))
    else $error("header state with empty group");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asgp_pkg::ST_MSB) |-> (idx_q < fill_i))
    else $error("MSB index beyond group fill");
  a_collect_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asgp_pkg::ST_COLLECT) |-> (fill_i < asgp_pkg::GROUP_CNT))
    else $error("full group left in collect state");
  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asgp_pkg::ST_MSB && !out_stall_i && last_msb)
    |=> (state_q == asgp_pkg::ST_COLLECT && fill_i == '0))
    else $error("group not cleared after last byte");
  a_last_not_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && msg_last_o) |-> !is_header_o)
    else $error("message end flagged on a header");
`endif

endmodule

// ----- hdl/adc_sample_group_packer.sv -----
// ADC sample group packer: one sample item per cycle while collecting; a
// full group or scan end is then sent as a header and n MSB bytes through
// the single output byte sequencer, during which input is stalled.
// Reset (rst_ni, asynchronous, active low) clears fill, header and state.
// Depends on asgp_pkg, asgp_group_buf and asgp_ctrl.
module adc_sample_group_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [asgp_pkg::SMP_W-1:0]   sample_i,
  input  logic                         scan_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [asgp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                         is_header_o,
  output logic                         msg_last_o
);

  asgp_pkg::buf_ctrl_t          ctrl;
  logic [asgp_pkg::HDR_W-1:0]   header;
  logic [asgp_pkg::BYTE_W-1:0]  rd_byte;
  logic [asgp_pkg::FILL_W-1:0]  fill;

  asgp_group_buf u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (sample_i),
    .header_o  (header),
    .rd_byte_o (rd_byte),
    .fill_o    (fill)
  );

  asgp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scan_end_i  (scan_end_i),
    .fill_i      (fill),
    .header_i    (header),
    .rd_byte_i   (rd_byte),
    .ctrl_o      (ctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_header_o (is_header_o),
    .msg_last_o  (msg_last_o)
  );

endmodule
